// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// File: sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared widths, codes, state type and divider interface types.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_TOTAL_DEF = 65536;
  localparam int WORD_BITS_DEF   = 64;

  localparam int KIND_W   = 3;
  localparam int START_W  = 16;
  localparam int COUNT_W  = 17;
  localparam int ALIGN_W  = 17;
  localparam int TYPE_W   = 4;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 17;
  // frame positions during search stay below 2^19
  localparam int POS_W    = 19;
  localparam int DCNT_W   = $clog2(POS_W + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC     = 3'd0,
    KIND_FREE      = 3'd1,
    KIND_RESTART   = 3'd2,
    KIND_INIT_DESC = 3'd3,
    KIND_REL_DESC  = 3'd4
  } kind_e;

  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

  localparam logic [TYPE_W-1:0] MTYPE_BOOT_CODE = 4'd3;
  localparam logic [TYPE_W-1:0] MTYPE_BOOT_DATA = 4'd4;
  localparam logic [TYPE_W-1:0] MTYPE_CONV      = 4'd7;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_DECODE,
    ST_ALCHK,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_RD,
    ST_EVAL,
    ST_JUMP_DIV,
    ST_JUMP_WAIT,
    ST_JUMP_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MODE_CHECK,
    MODE_SET,
    MODE_CLEAR
  } mode_e;

  typedef struct packed {
    logic             go;
    logic [POS_W-1:0] num;
    logic [POS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [POS_W-1:0] quo;
    logic [POS_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: sv/bfa_mem.sv
// ----------------------------------------------------------------------------
// Bitmap word memory
// Synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/bfa_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle; results hold after done.
// ----------------------------------------------------------------------------
module bfa_div import bfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [POS_W-1:0]  den_q, den_d;
  logic [POS_W-1:0]  quo_q, quo_d;
  logic [POS_W-1:0]  rem_q, rem_d;
  logic [POS_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[POS_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    den_d  = den_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DCNT_W'(1));
      quo_d  = {quo_q[POS_W-2:0], ge};
      rem_d  = ge ? POS_W'(trial - {1'b0, den_q}) : POS_W'(trial);
    end else if (req_i.go) begin
      cnt_d = DCNT_W'(POS_W);
      den_d = req_i.den;
      quo_d = req_i.num;
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: sv/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit aligned frame allocator over a used-bit map held in RAM.
//
//  channel | direction | signals
//  in      | input     | in_valid_i/in_ready_o, kind, run_first, run_len,
//          |           | run_align, mem_type
//  out     | output    | out_valid_o/out_ready_i, status, alloc_start, usable_end
//
// After reset and on a restart a fill pass writes every map word used,
// one word per cycle (FRAME_TOTAL/WORD_BITS words, 1024 by default).
// Accept in idle, then decode. Free and descriptor: split first and last
// frame into word and offset, then read and write back each map word.
// Alloc: per candidate a bound check and split, then a read of each word
// checked; a used frame starts a serial divide by the alignment and a
// realign multiply; a hit marks each word. Input is taken only when idle; one
// result waits in the output register and a held result stalls the next one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int FRAME_TOTAL = FRAME_TOTAL_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [START_W-1:0]  run_first_i,
  input  logic [COUNT_W-1:0]  run_len_i,
  input  logic [ALIGN_W-1:0]  run_align_i,
  input  logic [TYPE_W-1:0]   mem_type_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [START_W-1:0]  alloc_start_o,
  output logic [LIMIT_W-1:0]  usable_end_o
);

  localparam int MAP_WORDS = (FRAME_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OW        = $clog2(WORD_BITS);
  localparam int NF_W      = $clog2(FRAME_TOTAL + 1);
  localparam int CW        = (NF_W > POS_W) ? NF_W : POS_W;
  localparam logic [WORD_BITS-1:0] ONES = '1;
  // word index by reciprocal multiply, exact for positions below 2^POS_W
  localparam int RCP_SH = POS_W + 7;
  localparam int RCP_W  = RCP_SH - 2;
  localparam int PRD_W  = POS_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  state_e state_q, state_d;
  mode_e  mode_q;

  logic [KIND_W-1:0]   kind_q;
  logic [START_W-1:0]  start_q;
  logic [COUNT_W-1:0]  count_q;
  logic [ALIGN_W-1:0]  align_q;
  logic [TYPE_W-1:0]   mtype_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic                restart_q;
  logic [AW-1:0]       fill_cnt_q;

  logic [POS_W-1:0]    lo_q, hi_q, cand_q, jnum_q;
  logic [POS_W-1:0]    word_q, word_lo_q, word_hi_q, base_q, base_lo_q;
  logic [OW-1:0]       off_lo_q, off_hi_q;

  logic [STATUS_W-1:0] res_status_q;
  logic [START_W-1:0]  res_astart_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [START_W-1:0]  out_astart_q;
  logic [LIMIT_W-1:0]  out_end_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 mem_rd_en, mem_wr_en;
  logic [AW-1:0]        mem_rd_addr, mem_wr_addr;
  logic [WORD_BITS-1:0] mem_rd_data, mem_wr_data;

  // decode helpers
  logic [ALIGN_W-1:0] a_eff;
  logic [POS_W-1:0]   end_raw, end_clip, need_end;
  logic [LIMIT_W-1:0] end_s;
  logic               clip_ok, desc_free, fill_last, out_load, dec_ok;

  // word split
  logic [POS_W-1:0] split_num, split_quo, split_rem;
  logic [PRD_W-1:0] split_prd;

  // word evaluation
  logic [OW-1:0]        lo_off, hi_off, hibit;
  logic [WORD_BITS-1:0] mask, used_hits;
  logic                 hit, last_word;
  logic [POS_W-1:0]     used_pos;

  assign a_eff     = (align_q == '0) ? ALIGN_W'(1) : align_q;
  assign end_raw   = POS_W'(start_q) + POS_W'(count_q);
  assign end_clip  = (CW'(end_raw) > CW'(FRAME_TOTAL)) ? POS_W'(FRAME_TOTAL) : end_raw;
  assign clip_ok   = (CW'(start_q) < CW'(FRAME_TOTAL)) && (end_clip > POS_W'(start_q));
  assign desc_free = (mtype_q == MTYPE_CONV) || (mtype_q == MTYPE_BOOT_CODE);
  assign need_end  = cand_q + POS_W'(count_q);
  assign end_s     = (limit_q < LIMIT_W'(2)) ? LIMIT_W'(2) : limit_q;
  assign fill_last = (fill_cnt_q == AW'(MAP_WORDS - 1));
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign split_num = (state_q == ST_DIV_HI) ? hi_q : lo_q;
  assign split_prd = {{RCP_W{1'b0}}, split_num} * {{POS_W{1'b0}}, RCP};
  assign split_quo = POS_W'(split_prd >> RCP_SH);
  assign split_rem = split_num - POS_W'(split_quo * POS_W'(WORD_BITS));

  assign lo_off    = (word_q == word_lo_q) ? off_lo_q : '0;
  assign hi_off    = (word_q == word_hi_q) ? off_hi_q : OW'(WORD_BITS - 1);
  assign mask      = (ONES << lo_off) & (ONES >> (OW'(WORD_BITS - 1) - hi_off));
  assign used_hits = mem_rd_data & mask;
  assign hit       = |used_hits;
  assign last_word = (word_q == word_hi_q);
  assign used_pos  = base_q + POS_W'(hibit);

  always_comb begin
    hibit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (used_hits[i]) begin
        hibit = OW'(i);
      end
    end
  end

  always_comb begin
    case (kind_q)
      KIND_FREE:      dec_ok = clip_ok;
      KIND_RESTART:   dec_ok = 1'b1;
      KIND_INIT_DESC: dec_ok = clip_ok;
      KIND_REL_DESC:  dec_ok = clip_ok && (mtype_q == MTYPE_BOOT_DATA);
      default:        dec_ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (fill_last) state_d = restart_q ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (kind_q)
          KIND_ALLOC:     state_d = (count_q == '0) ? ST_DONE : ST_ALCHK;
          KIND_FREE:      state_d = clip_ok ? ST_DIV_LO : ST_DONE;
          KIND_RESTART:   state_d = ST_FILL;
          KIND_INIT_DESC: state_d = clip_ok ? ST_DIV_LO : ST_DONE;
          KIND_REL_DESC: begin
            state_d = (clip_ok && mtype_q == MTYPE_BOOT_DATA) ? ST_DIV_LO : ST_DONE;
          end
          default:        state_d = ST_DONE;
        endcase
      end
      ST_ALCHK:     state_d = (need_end > POS_W'(end_s)) ? ST_DONE : ST_DIV_LO;
      ST_DIV_LO:    state_d = ST_DIV_HI;
      ST_DIV_HI:    state_d = ST_RD;
      ST_RD:        state_d = ST_EVAL;
      ST_EVAL: begin
        if (mode_q == MODE_CHECK && hit) state_d = ST_JUMP_DIV;
        else if (last_word && mode_q != MODE_CHECK) state_d = ST_DONE;
        else state_d = ST_RD;
      end
      ST_JUMP_DIV:  state_d = ST_JUMP_WAIT;
      ST_JUMP_WAIT: if (div_rsp.done) state_d = ST_JUMP_MUL;
      ST_JUMP_MUL:  state_d = ST_ALCHK;
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs to memory and divider
  always_comb begin
    in_ready_o  = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_rd_addr = AW'(word_q);
    mem_wr_addr = AW'(word_q);
    mem_wr_data = (mode_q == MODE_SET) ? (mem_rd_data | mask) : (mem_rd_data & ~mask);
    div_req.go  = 1'b0;
    div_req.num = jnum_q;
    div_req.den = POS_W'(a_eff);
    case (state_q)
      ST_FILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fill_cnt_q;
        mem_wr_data = ONES;
      end
      ST_IDLE:     in_ready_o = 1'b1;
      ST_RD:       mem_rd_en = 1'b1;
      ST_EVAL:     mem_wr_en = (mode_q != MODE_CHECK);
      ST_JUMP_DIV: div_req.go = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_cnt_q  <= '0;
      restart_q   <= 1'b0;
      limit_q     <= LIMIT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FILL) begin
        fill_cnt_q <= fill_cnt_q + 1'b1;
        if (fill_last) restart_q <= 1'b0;
      end
      if (state_q == ST_DECODE) begin
        case (kind_q)
          KIND_RESTART: begin
            fill_cnt_q <= '0;
            restart_q  <= 1'b1;
            limit_q    <= LIMIT_W'(1);
          end
          KIND_INIT_DESC: begin
            if (clip_ok && desc_free && end_clip > POS_W'(limit_q)) begin
              limit_q <= LIMIT_W'(end_clip);
            end
          end
          KIND_REL_DESC: begin
            if (clip_ok && mtype_q == MTYPE_BOOT_DATA && end_clip > POS_W'(limit_q)) begin
              limit_q <= LIMIT_W'(end_clip);
            end
          end
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      start_q <= run_first_i;
      count_q <= run_len_i;
      align_q <= run_align_i;
      mtype_q <= mem_type_i;
    end
    case (state_q)
      ST_DECODE: begin
        res_astart_q <= '0;
        res_status_q <= dec_ok ? STAT_DONE : STAT_IGNORED;
        lo_q         <= POS_W'(start_q);
        hi_q         <= end_clip - 1'b1;
        mode_q       <= (kind_q == KIND_INIT_DESC && !desc_free) ? MODE_SET : MODE_CLEAR;
        cand_q       <= POS_W'(a_eff);
      end
      ST_ALCHK: begin
        res_status_q <= STAT_NOFIT;
        lo_q         <= cand_q;
        hi_q         <= need_end - 1'b1;
        mode_q       <= MODE_CHECK;
      end
      ST_DIV_LO: begin
        word_q    <= split_quo;
        word_lo_q <= split_quo;
        off_lo_q  <= OW'(split_rem);
        base_q    <= lo_q - split_rem;
        base_lo_q <= lo_q - split_rem;
      end
      ST_DIV_HI: begin
        word_hi_q <= split_quo;
        off_hi_q  <= OW'(split_rem);
      end
      ST_EVAL: begin
        if (mode_q == MODE_CHECK && hit) begin
          jnum_q <= used_pos + POS_W'(a_eff);
        end else if (mode_q == MODE_CHECK && last_word) begin
          mode_q       <= MODE_SET;
          word_q       <= word_lo_q;
          base_q       <= base_lo_q;
          res_status_q <= STAT_DONE;
          res_astart_q <= START_W'(cand_q);
        end else begin
          word_q <= word_q + 1'b1;
          base_q <= base_q + POS_W'(WORD_BITS);
        end
      end
      ST_JUMP_MUL: cand_q <= POS_W'(div_rsp.quo * POS_W'(a_eff));
      default: ;
    endcase
    if (out_load) begin
      out_status_q <= res_status_q;
      out_astart_q <= res_astart_q;
      out_end_q    <= limit_q;
    end
  end

  bfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bfa_mem #(
    .DEPTH (MAP_WORDS),
    .AW    (AW),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign alloc_start_o = out_astart_q;
  assign usable_end_o  = out_end_q;

  `ASSERT_PROP(a_idle_div_free, clk_i, rst_ni, in_ready_o |-> !div_rsp.busy)
  `ASSERT_NEVER(a_mem_one_port, clk_i, rst_ni, mem_rd_en && mem_wr_en)
  `ASSERT_PROP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `ASSERT_PROP(a_limit_drop, clk_i, rst_ni, (limit_q < $past(limit_q)) |-> $past(state_q == ST_DECODE))

endmodule

// File: tb/bfa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator checker
// Watches both channels, keeps its own copy of the used-frame map and usable
// end, predicts one result per input transaction and compares in order.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [START_W-1:0]  run_first_i,
  input  logic [COUNT_W-1:0]  run_len_i,
  input  logic [ALIGN_W-1:0]  run_align_i,
  input  logic [TYPE_W-1:0]   mem_type_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [START_W-1:0]  alloc_start_i,
  input  logic [LIMIT_W-1:0]  usable_end_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  localparam longint FRAMES = FRAME_TOTAL_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  alloc_start;
    logic [LIMIT_W-1:0]  usable_end;
  } alloc_rsp_t;

  bit         frame_used_q [FRAME_TOTAL_DEF];
  longint     usable_end_q;
  alloc_rsp_t rsp_fifo [$];
  int         fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = rsp_fifo.size();

  function automatic void fill_map();
    for (int f = 0; f < FRAME_TOTAL_DEF; f++) frame_used_q[f] = 1'b1;
    usable_end_q = 1;
  endfunction

  function automatic void mark_frames(longint first, longint last, bit val);
    for (longint f = first; f < last && f < FRAMES; f++) frame_used_q[f] = val;
  endfunction

  function automatic longint align_up(longint v, longint a);
    return (v + a - 1) / a * a;
  endfunction

  function automatic bit seek_run(longint need, longint algn, output longint at);
    longint lim;
    longint pos;
    longint i;
    lim = (usable_end_q < 2) ? 2 : usable_end_q;
    pos = align_up(1, algn);
    at  = 0;
    while (pos + need <= lim) begin
      i = 0;
      while (i < need && !frame_used_q[pos + i]) i++;
      if (i == need) begin
        at = pos;
        return 1'b1;
      end
      pos = align_up(pos + i + 1, algn);
    end
    return 1'b0;
  endfunction

  function automatic bit clip_range(longint s, longint c, output longint e);
    e = s + c;
    if (s >= FRAMES) return 1'b0;
    if (e > FRAMES) e = FRAMES;
    return e > s;
  endfunction

  function automatic alloc_rsp_t predict_alloc(logic [KIND_W-1:0] k, longint s,
                                                longint c, longint algn,
                                                logic [TYPE_W-1:0] mt);
    alloc_rsp_t r;
    longint     e;
    longint     at;
    r = '0;
    r.status = STAT_IGNORED;
    case (k)
      KIND_ALLOC: if (c != 0) begin
        if (algn == 0) algn = 1;
        if (seek_run(c, algn, at)) begin
          mark_frames(at, at + c, 1'b1);
          r.alloc_start = at[START_W-1:0];
          r.status = STAT_DONE;
        end else begin
          r.status = STAT_NOFIT;
        end
      end
      KIND_FREE: if (c != 0 && clip_range(s, c, e)) begin
        mark_frames(s, e, 1'b0);
        r.status = STAT_DONE;
      end
      KIND_RESTART: begin
        fill_map();
        r.status = STAT_DONE;
      end
      KIND_INIT_DESC: if (clip_range(s, c, e)) begin
        if (mt == MTYPE_CONV || mt == MTYPE_BOOT_CODE) begin
          mark_frames(s, e, 1'b0);
          if (e > usable_end_q) usable_end_q = e;
        end else begin
          mark_frames(s, e, 1'b1);
        end
        r.status = STAT_DONE;
      end
      KIND_REL_DESC: if (mt == MTYPE_BOOT_DATA && clip_range(s, c, e)) begin
        mark_frames(s, e, 1'b0);
        if (e > usable_end_q) usable_end_q = e;
        r.status = STAT_DONE;
      end
      default: ;
    endcase
    r.usable_end = usable_end_q[LIMIT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t exp_r;
    if (!rst_ni) begin
      fill_map();
      rsp_fifo.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        rsp_fifo.push_back(predict_alloc(kind_i, longint'(run_first_i),
                                         longint'(run_len_i), longint'(run_align_i),
                                         mem_type_i));
      if (out_valid_i && out_ready_i) begin
        if (rsp_fifo.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result transaction");
        end else begin
          exp_r = rsp_fifo.pop_front();
          if (exp_r.status != status_i || exp_r.alloc_start != alloc_start_i ||
              exp_r.usable_end != usable_end_i) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp st=%0d at=%0d end=%0d got st=%0d at=%0d end=%0d",
                       exp_r.status, exp_r.alloc_start, exp_r.usable_end,
                       status_i, alloc_start_i, usable_end_i);
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_bitmap_frame_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Directed corner transactions, then random traffic of every kind over a
// small usable range, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  localparam int NUM_RAND  = 1500;
  localparam int MAX_CYCLE = 50000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   kind;
  logic [START_W-1:0]  run_first;
  logic [COUNT_W-1:0]  run_len;
  logic [ALIGN_W-1:0]  run_align;
  logic [TYPE_W-1:0]   mem_type;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  alloc_start;
  logic [LIMIT_W-1:0]  usable_end;
  int                  fail_cnt;
  int                  pending;
  int                  cycle_cnt = 0;
  bit                  no_idle;

  bitmap_frame_allocator u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .run_first_i(run_first), .run_len_i(run_len),
    .run_align_i(run_align), .mem_type_i(mem_type),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .alloc_start_o(alloc_start), .usable_end_o(usable_end)
  );

  bfa_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .run_first_i(run_first), .run_len_i(run_len),
    .run_align_i(run_align), .mem_type_i(mem_type),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .alloc_start_i(alloc_start), .usable_end_i(usable_end),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_valid = 1'b0; out_ready = 1'b0; kind = '0; run_first = '0;
    run_len = '0; run_align = '0; mem_type = '0; no_idle = 1'b0;
  end

  always @(posedge clk) out_ready <= no_idle || ($urandom_range(99) >= 29);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("[bitmap_frame_allocator] ERROR");
      $finish;
    end
  end

  task automatic send(logic [KIND_W-1:0] k, int s, int c, int a,
                      logic [TYPE_W-1:0] mt);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; kind <= k; run_first <= START_W'(s);
    run_len <= COUNT_W'(c); run_align <= ALIGN_W'(a); mem_type <= mt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    int sel;
    int a;
    sel = $urandom_range(99);
    case ($urandom_range(5))
      0: a = 0;
      1: a = 1;
      2: a = 2;
      3: a = 4;
      4: a = 8;
      default: a = $urandom_range(20);
    endcase
    if ($urandom_range(49) == 0) a = $urandom_range(131071);
    if (sel < 40)
      send(KIND_ALLOC, $urandom, ($urandom_range(19) == 0) ? $urandom_range(131071)
           : $urandom_range(12), a, TYPE_W'($urandom));
    else if (sel < 55) begin
      if ($urandom_range(4) == 0)
        send(KIND_FREE, $urandom, $urandom_range(131071), $urandom, TYPE_W'($urandom));
      else
        send(KIND_FREE, $urandom_range(200), $urandom_range(40), $urandom,
             TYPE_W'($urandom));
    end else if (sel < 70)
      send(KIND_INIT_DESC, $urandom_range(200), $urandom_range(60), $urandom,
           $urandom_range(1) ? MTYPE_CONV : MTYPE_BOOT_CODE);
    else if (sel < 76)
      send(KIND_INIT_DESC, $urandom, $urandom_range(131071), $urandom,
           ($urandom_range(15) == 0) ? 4'd15 : 4'($urandom_range(2) == 0 ? 0 : 6));
    else if (sel < 86)
      send(KIND_REL_DESC, $urandom_range(200), $urandom_range(60), $urandom,
           ($urandom_range(3) == 0) ? 4'($urandom) : MTYPE_BOOT_DATA);
    else if (sel < 90)
      send(KIND_RESTART, $urandom, $urandom, $urandom, TYPE_W'($urandom));
    else
      send(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, TYPE_W'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(KIND_ALLOC, 0, 0, 0, 4'd0);
    send(KIND_ALLOC, 0, 1, 0, 4'd0);
    send(KIND_INIT_DESC, 0, 0, 0, MTYPE_CONV);
    send(KIND_INIT_DESC, 0, 64, 0, MTYPE_CONV);
    send(KIND_ALLOC, 0, 1, 0, 4'd0);
    send(KIND_ALLOC, 0, 3, 4, 4'd0);
    send(KIND_ALLOC, 0, 65536, 1, 4'd0);
    send(KIND_ALLOC, 0, 1, 65536, 4'd0);
    send(KIND_FREE, 65535, 65536, 0, 4'd0);
    send(KIND_FREE, 10, 0, 0, 4'd0);
    send(KIND_INIT_DESC, 100, 20, 0, MTYPE_BOOT_CODE);
    send(KIND_INIT_DESC, 40000, 300, 0, 4'd5);
    send(KIND_REL_DESC, 130, 10, 0, MTYPE_BOOT_DATA);
    send(KIND_REL_DESC, 150, 10, 0, MTYPE_CONV);
    send(3'd5, 'hFFFF, 'h1FFFF, 'h1FFFF, 4'hF);
    send(3'd6, 0, 0, 0, 4'd0);
    send(3'd7, 0, 1, 1, 4'd0);
    send(KIND_INIT_DESC, 0, 65536, 0, MTYPE_CONV);
    send(KIND_ALLOC, 0, 100, 0, 4'd0);
    send(KIND_ALLOC, 0, 1, 65536, 4'd0);
    send(KIND_ALLOC, 0, 65535, 1, 4'd0);
    send(KIND_INIT_DESC, 'hFFFF, 'h1FFFF, 'h1FFFF, 4'hF);
    send(KIND_RESTART, 0, 0, 0, 4'd0);

    for (int n = 0; n < NUM_RAND; n++) begin
      no_idle <= (n >= 600 && n < 900);
      send_random();
    end
    in_valid <= 1'b0;
    no_idle <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0)
      $display("[bitmap_frame_allocator] OK");
    else
      $display("[bitmap_frame_allocator] ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bfa_pkg.sv
sv/bfa_mem.sv
sv/bfa_div.sv
sv/bitmap_frame_allocator.sv
tb/bfa_checker.sv
tb/tb_bitmap_frame_allocator.sv
